// ===== hdl/dlr_pkg.sv =====
// dlr_pkg: shared types, constants and register codes of the downmix, lowpass and
// resample block
// no dependencies
package dlr_pkg;

   localparam int MAX_CHANNELS_DEF   = 32;
   localparam int SAMPLE_BITS_DEF    = 24;
   localparam int COEF_FRAC_BITS_DEF = 28;

   localparam int SIG_FRAC    = 30;     // mono signal fraction bits
   localparam int RECIP_BITS  = 24;     // reciprocal rom fraction bits
   localparam int PHASE_BITS  = 24;     // resampler phase fraction bits
   localparam int ROM_DEPTH   = 64;
   localparam int COUNT_W     = 6;
   localparam int STEP_W      = 28;
   localparam int COEF_W      = 32;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int PCM_W       = 16;
   localparam int PCM_SCALE   = 32767;
   localparam int SIG_W       = 32;
   localparam int DELAY_W     = 40;
   localparam int OFFSET_W    = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CHANNEL_COUNT,
      CSR_RESAMPLE_STEP,
      CSR_STAGE_ONE_B0,
      CSR_STAGE_ONE_A1,
      CSR_STAGE_ONE_A2,
      CSR_STAGE_TWO_B0,
      CSR_STAGE_TWO_A1,
      CSR_STAGE_TWO_A2
   } csr_index_type;

   // coefficient pairs: index 0 is stage one, index 1 is stage two
   typedef struct packed {
      logic [COUNT_W-1:0]            channel_count;
      logic [STEP_W-1:0]             resample_step;
      logic [1:0][COEF_W-1:0]        b0;
      logic [1:0][COEF_W-1:0]        a1;
      logic [1:0][COEF_W-1:0]        a2;
   } cfg_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MONO_MUL,
      S_MONO_RES,
      S_B0_MUL,
      S_B0_RES,
      S_A1_MUL,
      S_A1_RES,
      S_A2_MUL,
      S_A2_RES,
      S_INT_CHECK,
      S_INT_MUL,
      S_INT_RES,
      S_PCM_MUL,
      S_PCM_RES,
      S_EMIT,
      S_DONE
   } state_type;

endpackage

// ===== hdl/dlr_csr.sv =====
// dlr_csr: configuration register file, write only
// depends on dlr_pkg
module dlr_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [dlr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dlr_pkg::CSR_DATA_W-1:0] csr_wdata,
   output dlr_pkg::cfg_type               cfg
);
   import dlr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_CHANNEL_COUNT: cfg_in.channel_count = csr_wdata[COUNT_W-1:0];
            CSR_RESAMPLE_STEP: cfg_in.resample_step = csr_wdata[STEP_W-1:0];
            CSR_STAGE_ONE_B0:  cfg_in.b0[0] = csr_wdata[COEF_W-1:0];
            CSR_STAGE_ONE_A1:  cfg_in.a1[0] = csr_wdata[COEF_W-1:0];
            CSR_STAGE_ONE_A2:  cfg_in.a2[0] = csr_wdata[COEF_W-1:0];
            CSR_STAGE_TWO_B0:  cfg_in.b0[1] = csr_wdata[COEF_W-1:0];
            CSR_STAGE_TWO_A1:  cfg_in.a1[1] = csr_wdata[COEF_W-1:0];
            CSR_STAGE_TWO_A2:  cfg_in.a2[1] = csr_wdata[COEF_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff               <= '0;
         cfg_ff.channel_count <= COUNT_W'(1);
         cfg_ff.resample_step <= STEP_W'(1) << PHASE_BITS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/dlr_mul.sv =====
// dlr_mul: shared signed multiplier with registered product
// depends on dlr_pkg
module dlr_mul #(
   parameter int MUL_W = 34
) (
   input  logic                      clock,
   input  logic signed [MUL_W-1:0]   op_a,
   input  logic signed [MUL_W-1:0]   op_b,
   output logic signed [2*MUL_W-1:0] product
);
   import dlr_pkg::*;

   logic signed [2*MUL_W-1:0] product_ff;
   logic signed [2*MUL_W-1:0] product_in;

   assign product_in = op_a * op_b;

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

// ===== hdl/downmix_lowpass_resampler_unit.sv =====
// downmix_lowpass_resampler_unit: frame downmix, two-stage biquad lowpass, linear resampler
// depends on dlr_pkg, dlr_csr, dlr_mul
// a sample that does not close a frame is only summed; a frame-closing sample runs
//   the downmix, both biquads (only when step > 1.0), then interpolate and scale per output
// throughput: one transaction at a time; all products go through the one shared multiplier
// reset: synchronous active high, clears sums, filter delays, phase and sets first frame
module downmix_lowpass_resampler_unit #(
   parameter int MAX_CHANNELS   = dlr_pkg::MAX_CHANNELS_DEF,
   parameter int SAMPLE_BITS    = dlr_pkg::SAMPLE_BITS_DEF,
   parameter int COEF_FRAC_BITS = dlr_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // sample stream
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       req_tdata,   // [SAMPLE_BITS-1:0] sample
   // pcm stream
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [dlr_pkg::PCM_W-1:0]              rsp_tdata,   // [15:0] pcm
   output logic                                   rsp_tlast,   // last_of_run
   // configuration writes
   input  logic                                   csr_we,
   input  logic [dlr_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [dlr_pkg::CSR_DATA_W-1:0]         csr_wdata
);
   import dlr_pkg::*;

   localparam int SEEN_W     = $clog2(MAX_CHANNELS + 1);
   localparam int SUM_W      = SAMPLE_BITS + $clog2(MAX_CHANNELS);
   localparam int MUL_W      = (SUM_W + 1 > 34) ? SUM_W + 1 : 34;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int WIDE_W     = PROD_W + 4;
   localparam int MONO_SHIFT = SAMPLE_BITS - 1 + RECIP_BITS - SIG_FRAC;
   localparam int NCNT_W     = COUNT_W + 2;

   localparam logic signed [WIDE_W-1:0] MAX32 = WIDE_W'((64'sd1 <<< 31) - 64'sd1);
   localparam logic signed [WIDE_W-1:0] MIN32 = WIDE_W'(-(64'sd1 <<< 31));
   localparam logic signed [WIDE_W-1:0] MAX40 = WIDE_W'((64'sd1 <<< 39) - 64'sd1);
   localparam logic signed [WIDE_W-1:0] MIN40 = WIDE_W'(-(64'sd1 <<< 39));
   localparam logic signed [WIDE_W-1:0] ONE_SIG = WIDE_W'(64'sd1 <<< SIG_FRAC);
   localparam logic [SIG_FRAC-1:0]      HALF_SIG = SIG_FRAC'(1) << (SIG_FRAC - 1);

   // rounding shift, ties upward
   function automatic logic signed [WIDE_W-1:0] rnd(input logic signed [WIDE_W-1:0] v,
                                                    input int s);
      logic signed [WIDE_W-1:0] half;
      half = '0;
      half[s-1] = 1'b1;
      return (v + half) >>> s;
   endfunction

   function automatic logic signed [SIG_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] c;
      c = (v > MAX32) ? MAX32 : ((v < MIN32) ? MIN32 : v);
      return c[SIG_W-1:0];
   endfunction

   function automatic logic signed [DELAY_W-1:0] sat40(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] c;
      c = (v > MAX40) ? MAX40 : ((v < MIN40) ? MIN40 : v);
      return c[DELAY_W-1:0];
   endfunction

   // configuration
   cfg_type cfg;

   dlr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // reciprocal rom, round(2^24 / n), entry zero unused
   logic [RECIP_BITS:0] recip_rom [ROM_DEPTH];
   for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_recip
      localparam longint DIV = (g == 0) ? 1 : g;
      localparam longint RV  = ((64'sd1 <<< RECIP_BITS) + DIV / 2) / DIV;
      assign recip_rom[g] = (RECIP_BITS + 1)'(RV);
   end

   // state
   state_type state_ff, state_in;

   logic signed [SUM_W-1:0]    sum_ff;
   logic [SEEN_W-1:0]          seen_ff;
   logic signed [DELAY_W-1:0]  z0_ff [2];
   logic signed [DELAY_W-1:0]  z1_ff [2];
   logic signed [DELAY_W-1:0]  n0_ff;
   logic signed [SIG_W-1:0]    prev_ff;
   logic signed [SIG_W-1:0]    cur_ff;
   logic signed [PROD_W-1:0]   bp_ff;
   logic signed [SIG_W-1:0]    val_ff;
   logic [PCM_W-1:0]           pcm_ff;
   logic                       last_ff;
   logic signed [OFFSET_W-1:0] offset_ff;
   logic                       first_ff;
   logic [1:0]                 count_ff;
   logic                       stage_ff;
   logic                       rsp_tvalid_ff;
   logic [PCM_W-1:0]           rsp_tdata_ff;
   logic                       rsp_tlast_ff;

   // channel count clamp and frame end
   logic [NCNT_W-1:0]          n_eff;
   logic                       frame_end;
   logic                       req_fire;
   logic signed [SUM_W-1:0]    sample_ext;
   logic signed [SUM_W-1:0]    sum_next;

   always_comb begin
      if (cfg.channel_count == '0) begin
         n_eff = NCNT_W'(1);
      end else if (NCNT_W'(cfg.channel_count) > NCNT_W'(MAX_CHANNELS)) begin
         n_eff = NCNT_W'(MAX_CHANNELS);
      end else begin
         n_eff = NCNT_W'(cfg.channel_count);
      end
   end

   assign req_fire   = req_tvalid && req_tready;
   assign frame_end  = (NCNT_W'(seen_ff) + NCNT_W'(1)) >= n_eff;
   assign sample_ext = SUM_W'($signed(req_tdata[SAMPLE_BITS-1:0]));
   assign sum_next   = sum_ff + sample_ext;

   // step handling: lowpass above unity, step floor of one half
   logic                       filter_on;
   logic [STEP_W-1:0]          step_eff;
   logic signed [OFFSET_W:0]   offset_step;
   logic signed [OFFSET_W:0]   frac;

   assign filter_on   = cfg.resample_step > (STEP_W'(1) << PHASE_BITS);
   assign step_eff    = (cfg.resample_step < (STEP_W'(1) << (PHASE_BITS - 1))) ?
                        (STEP_W'(1) << (PHASE_BITS - 1)) : cfg.resample_step;
   assign offset_step = (OFFSET_W + 1)'(offset_ff) + (OFFSET_W + 1)'({1'b0, step_eff});
   assign frac        = first_ff ? '0 :
                        (OFFSET_W + 1)'(offset_ff) + ((OFFSET_W + 1)'(1) <<< PHASE_BITS);

   // shared multiplier
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] product;
   logic signed [WIDE_W-1:0] pw;

   dlr_mul #(.MUL_W(MUL_W)) u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (product)
   );

   assign pw = WIDE_W'(product);

   // next state
   logic emit_load;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:      if (req_fire && frame_end) state_in = S_MONO_MUL;
         S_MONO_MUL:  state_in = S_MONO_RES;
         S_MONO_RES:  state_in = filter_on ? S_B0_MUL : S_INT_CHECK;
         S_B0_MUL:    state_in = S_B0_RES;
         S_B0_RES:    state_in = S_A1_MUL;
         S_A1_MUL:    state_in = S_A1_RES;
         S_A1_RES:    state_in = S_A2_MUL;
         S_A2_MUL:    state_in = S_A2_RES;
         S_A2_RES:    state_in = stage_ff ? S_INT_CHECK : S_B0_MUL;
         S_INT_CHECK: state_in = (offset_ff <= 0 && count_ff < 2'd2) ? S_INT_MUL : S_DONE;
         S_INT_MUL:   state_in = S_INT_RES;
         S_INT_RES:   state_in = S_PCM_MUL;
         S_PCM_MUL:   state_in = S_PCM_RES;
         S_PCM_RES:   state_in = S_EMIT;
         S_EMIT:      if (emit_load) state_in = S_INT_CHECK;
         S_DONE:      state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   // control outputs and multiplier operand select
   always_comb begin
      req_tready = (state_ff == S_IDLE);
      emit_load  = (state_ff == S_EMIT) && (!rsp_tvalid_ff || rsp_tready);
      mul_a      = '0;
      mul_b      = '0;
      case (state_ff)
         S_MONO_MUL: begin
            mul_a = MUL_W'(sum_ff);
            mul_b = MUL_W'($signed({1'b0, recip_rom[n_eff[COUNT_W-1:0]]}));
         end
         S_B0_MUL: begin
            mul_a = MUL_W'($signed(cfg.b0[stage_ff]));
            mul_b = MUL_W'(cur_ff);
         end
         S_A1_MUL: begin
            mul_a = MUL_W'($signed(cfg.a1[stage_ff]));
            mul_b = MUL_W'(cur_ff);
         end
         S_A2_MUL: begin
            mul_a = MUL_W'($signed(cfg.a2[stage_ff]));
            mul_b = MUL_W'(cur_ff);
         end
         S_INT_MUL: begin
            mul_a = MUL_W'(cur_ff) - MUL_W'(prev_ff);
            mul_b = MUL_W'(frac);
         end
         S_PCM_MUL: begin
            mul_a = MUL_W'(val_ff);
            mul_b = MUL_W'(PCM_SCALE);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // datapath arithmetic per state
   logic signed [WIDE_W-1:0] bpw;
   logic signed [WIDE_W-1:0] y_sum;
   logic signed [WIDE_W-1:0] n0_sum;
   logic signed [WIDE_W-1:0] n1_sum;
   logic signed [WIDE_W-1:0] interp;
   logic signed [WIDE_W-1:0] interp_clamp;
   logic signed [WIDE_W-1:0] pq;
   logic [SIG_FRAC-1:0]      pr;
   logic                     round_up;

   assign bpw    = WIDE_W'(bp_ff);
   assign y_sum  = rnd(pw, COEF_FRAC_BITS) + WIDE_W'(z0_ff[stage_ff]);
   // feedforward b1 is twice b0, hence one less shift
   assign n0_sum = rnd(bpw, COEF_FRAC_BITS - 1) - rnd(pw, COEF_FRAC_BITS)
                   + WIDE_W'(z1_ff[stage_ff]);
   assign n1_sum = rnd(bpw, COEF_FRAC_BITS) - rnd(pw, COEF_FRAC_BITS);
   assign interp = WIDE_W'(prev_ff) + rnd(pw, PHASE_BITS);
   assign interp_clamp = (interp > ONE_SIG) ? ONE_SIG :
                         ((interp < -ONE_SIG) ? -ONE_SIG : interp);
   // pcm rounding to nearest, ties to even
   assign pq       = pw >>> SIG_FRAC;
   assign pr       = pw[SIG_FRAC-1:0];
   assign round_up = (pr > HALF_SIG) || ((pr == HALF_SIG) && pq[0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         sum_ff        <= '0;
         seen_ff       <= '0;
         z0_ff[0]      <= '0;
         z0_ff[1]      <= '0;
         z1_ff[0]      <= '0;
         z1_ff[1]      <= '0;
         prev_ff       <= '0;
         offset_ff     <= '0;
         first_ff      <= 1'b1;
         count_ff      <= '0;
         stage_ff      <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         // output register drains unless a new transaction loads it
         if (rsp_tvalid_ff && rsp_tready && !emit_load) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  sum_ff  <= sum_next;
                  seen_ff <= frame_end ? '0 : seen_ff + SEEN_W'(1);
               end
            end
            S_MONO_RES: begin
               cur_ff   <= sat32(rnd(pw, MONO_SHIFT));
               sum_ff   <= '0;
               stage_ff <= 1'b0;
               count_ff <= '0;
            end
            S_B0_RES: begin
               bp_ff  <= product;
               cur_ff <= sat32(y_sum);
            end
            S_A1_RES: begin
               n0_ff <= sat40(n0_sum);
            end
            S_A2_RES: begin
               z0_ff[stage_ff] <= n0_ff;
               z1_ff[stage_ff] <= sat40(n1_sum);
               stage_ff        <= 1'b1;
            end
            S_INT_CHECK: begin
               // the first frame interpolates against itself
               if (first_ff) prev_ff <= cur_ff;
            end
            S_INT_RES: begin
               val_ff <= interp_clamp[SIG_W-1:0];
            end
            S_PCM_RES: begin
               pcm_ff  <= pq[PCM_W-1:0] + PCM_W'(round_up);
               last_ff <= (count_ff == 2'd1) || (offset_step > 0);
            end
            S_EMIT: begin
               if (emit_load) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_tdata_ff  <= pcm_ff;
                  rsp_tlast_ff  <= last_ff;
                  count_ff      <= count_ff + 2'd1;
                  offset_ff     <= offset_step[OFFSET_W-1:0];
               end
            end
            S_DONE: begin
               prev_ff   <= cur_ff;
               offset_ff <= offset_ff - (OFFSET_W'(1) <<< PHASE_BITS);
               first_ff  <= 1'b0;
            end
            default: begin
               first_ff <= first_ff;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

`ifndef SYNTH
   // at most two outputs per frame
   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("output count above two");

   // a frame-closing transaction starts the downmix multiply
   a_frame_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_fire && frame_end) |=> (state_ff == S_MONO_MUL))
      else $error("frame end did not start downmix");

   // the output loop only ends on the count limit or a positive phase
   a_loop_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |-> (count_ff == 2'd2 || offset_ff > 0))
      else $error("output loop ended early");
`endif

endmodule

// ===== sim/tb_downmix_lowpass_resampler_unit.sv =====
// tb_downmix_lowpass_resampler_unit: self-checking bench for the downmix, lowpass and resample
// block, with a bit-true predictor and a queue of expected pcm transactions
// depends on dlr_pkg and downmix_lowpass_resampler_unit
`timescale 1ns / 100ps

module tb_downmix_lowpass_resampler_unit;
   import dlr_pkg::*;

   localparam int  CLK_PERIOD   = 20;
   localparam int  SETTLE       = 40;     // longest frame, with margin
   localparam int  STALL_LIMIT  = 50000;  // cycles with no transaction on either side
   localparam int  RANDOM_ITEMS = 1100;
   localparam int  HOLD_CYCLES  = 400;

   typedef struct {
      logic [PCM_W-1:0] pcm;
      logic             last;
   } pcm_result_type;

   // predictor of the mono pcm stream plus the queue of pcm transactions still owed
   class downmix_predictor;
      logic [COUNT_W-1:0] count_reg;
      logic [STEP_W-1:0]  step_reg;
      longint             coef [6];
      longint             sum;
      int                 seen;
      longint             delay [2][2];
      longint             prev_mono;
      longint             offset;
      bit                 first;
      pcm_result_type     expected_pcm [$];
      int                 errors;

      function new();
         count_reg = COUNT_W'(1);
         step_reg  = STEP_W'(1) << PHASE_BITS;
         foreach (coef[i]) coef[i] = 0;
         sum = 0;
         seen = 0;
         foreach (delay[i, j]) delay[i][j] = 0;
         prev_mono = 0;
         offset = 0;
         first = 1;
         errors = 0;
      endfunction

      function void set_register(csr_index_type idx, logic [CSR_DATA_W-1:0] v);
         case (idx)
            CSR_CHANNEL_COUNT: count_reg = v[COUNT_W-1:0];
            CSR_RESAMPLE_STEP: step_reg  = v[STEP_W-1:0];
            CSR_STAGE_ONE_B0:  coef[0]   = longint'(signed'(v));
            CSR_STAGE_ONE_A1:  coef[1]   = longint'(signed'(v));
            CSR_STAGE_ONE_A2:  coef[2]   = longint'(signed'(v));
            CSR_STAGE_TWO_B0:  coef[3]   = longint'(signed'(v));
            CSR_STAGE_TWO_A1:  coef[4]   = longint'(signed'(v));
            default:           coef[5]   = longint'(signed'(v));
         endcase
      endfunction

      // round to nearest, ties upward
      function longint round_shift(longint v, int s);
         return (v + (longint'(1) << (s - 1))) >>> s;
      endfunction

      function longint clip(longint v, int bits);
         longint hi;
         hi = (longint'(1) << (bits - 1)) - 1;
         return v > hi ? hi : (v < -hi - 1 ? -hi - 1 : v);
      endfunction

      function longint biquad(int stage, longint x);
         longint p, y, n0, n1;
         p  = coef[3*stage] * x;
         y  = clip(round_shift(p, COEF_FRAC_BITS_DEF) + delay[stage][0], SIG_W);
         n0 = round_shift(p, COEF_FRAC_BITS_DEF - 1)
            - round_shift(coef[3*stage+1] * y, COEF_FRAC_BITS_DEF) + delay[stage][1];
         n1 = round_shift(p, COEF_FRAC_BITS_DEF)
            - round_shift(coef[3*stage+2] * y, COEF_FRAC_BITS_DEF);
         delay[stage][0] = clip(n0, DELAY_W);
         delay[stage][1] = clip(n1, DELAY_W);
         return y;
      endfunction

      // saturate to +-1.0, scale by 32767, round half to even
      function logic [PCM_W-1:0] scale_pcm(longint v);
         longint one, p, q, r;
         one = longint'(1) << SIG_FRAC;
         if (v > one) v = one;
         if (v < -one) v = -one;
         p = v * PCM_SCALE;
         q = p >>> SIG_FRAC;
         r = p - (q << SIG_FRAC);
         if (r > (one >>> 1) || (r == (one >>> 1) && q[0])) q++;
         return q[PCM_W-1:0];
      endfunction

      function void accept_sample(logic [SAMPLE_BITS_DEF-1:0] raw);
         longint n, recip, cur, stp, frac, val;
         int produced;
         pcm_result_type res;
         n = count_reg;
         if (n < 1) n = 1;
         if (n > MAX_CHANNELS_DEF) n = MAX_CHANNELS_DEF;
         sum += longint'(signed'(raw));
         seen++;
         if (seen < n) return;
         // frame closed (a lowered count closes it at once)
         recip = ((longint'(1) << RECIP_BITS) + n / 2) / n;
         cur = clip(round_shift(sum * recip, SAMPLE_BITS_DEF - 1 + RECIP_BITS - SIG_FRAC), SIG_W);
         sum = 0;
         seen = 0;
         if (step_reg > (1 << PHASE_BITS)) begin
            cur = biquad(0, cur);
            cur = biquad(1, cur);
         end
         if (first) prev_mono = cur;
         stp = step_reg;
         if (stp < (longint'(1) << (PHASE_BITS - 1))) stp = longint'(1) << (PHASE_BITS - 1);
         produced = 0;
         while (offset <= 0 && produced < 2) begin
            frac = first ? 0 : offset + (longint'(1) << PHASE_BITS);
            val = prev_mono + round_shift((cur - prev_mono) * frac, PHASE_BITS);
            res.pcm = scale_pcm(val);
            res.last = 0;
            expected_pcm.push_back(res);
            produced++;
            offset += stp;
         end
         if (produced > 0) expected_pcm[$].last = 1;
         prev_mono = cur;
         offset -= longint'(1) << PHASE_BITS;
         first = 0;
      endfunction

      function void check_pcm(logic [PCM_W-1:0] pcm, logic last);
         pcm_result_type want;
         if (expected_pcm.size() == 0) begin
            $error("unexpected pcm transaction: pcm %0d last %0b", signed'(pcm), last);
            errors++;
            return;
         end
         want = expected_pcm.pop_front();
         if (pcm !== want.pcm) begin
            $error("pcm mismatch: expected %0d actual %0d", signed'(want.pcm), signed'(pcm));
            errors++;
         end
         if (last !== want.last) begin
            $error("last_of_run mismatch: expected %0b actual %0b", want.last, last);
            errors++;
         end
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [23:0]               req_tdata;   // [23:0] sample
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [PCM_W-1:0]          rsp_tdata;   // [15:0] pcm
   logic                      rsp_tlast;   // last_of_run
   logic                      csr_we;
   logic [CSR_IDX_W-1:0]      csr_index;
   logic [CSR_DATA_W-1:0]     csr_wdata;

   downmix_predictor          pcm_model;
   int                        samples_sent;
   int                        quiet_cycles;

   downmix_lowpass_resampler_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // no idling on either side for a stretch in the middle of the random part
   function automatic bit steady_stretch();
      return samples_sent >= 300 && samples_sent < 500;
   endfunction

   // one register write; the predictor takes it at the same edge
   // the caller drops the write enable after the last write of a burst
   task automatic csr_write(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      pcm_model.set_register(idx, value);
   endtask

   // coefficient sets: 0 a tame butterworth-like pair, 1 random, 2 rail values
   task automatic program_block(logic [CSR_DATA_W-1:0] channels, logic [CSR_DATA_W-1:0] step,
                                int coef_mode);
      logic [CSR_DATA_W-1:0] c [6];
      case (coef_mode)
         0: begin
            c = '{32'd18119393, -32'sd306821726, 32'd110810157,
                  32'd18119393, -32'sd365072220, 32'd169114337};
         end
         1: begin
            foreach (c[i]) c[i] = $urandom();
         end
         default: begin
            foreach (c[i]) c[i] = $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
         end
      endcase
      csr_write(CSR_CHANNEL_COUNT, channels);
      csr_write(CSR_RESAMPLE_STEP, step);
      csr_write(CSR_STAGE_ONE_B0, c[0]);
      csr_write(CSR_STAGE_ONE_A1, c[1]);
      csr_write(CSR_STAGE_ONE_A2, c[2]);
      csr_write(CSR_STAGE_TWO_B0, c[3]);
      csr_write(CSR_STAGE_TWO_A1, c[4]);
      csr_write(CSR_STAGE_TWO_A2, c[5]);
      csr_we <= 1'b0;
   endtask

   // offer one sample, with random gaps, until the block takes it
   task automatic send_sample(logic [23:0] value);
      while (!steady_stretch() && $urandom_range(99) < 24) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      pcm_model.accept_sample(value);
      samples_sent++;
   endtask

   // drain everything owed, then let a frame that emits nothing finish
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pcm_model.expected_pcm.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic logic [23:0] pick_sample();
      case ($urandom_range(9))
         0:       return $urandom_range(1) ? 24'h7fffff : 24'h800000;
         1:       return 24'($signed($urandom_range(512)) - 256);
         default: return 24'($urandom());
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_step();
      case ($urandom_range(9))
         0:       return $urandom_range(8388607);                 // raised to 0.5
         1:       return $urandom_range(1) ? 32'd8388608 : 32'd201326592;
         2:       return $urandom_range(268435455, 201326593);     // beyond nominal top
         3:       return 32'd16777216;                             // exactly 1.0, filter off
         default: return $urandom_range(50331648, 8388608);
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_channels();
      case ($urandom_range(9))
         0:       return $urandom_range(1) ? 32'd0 : 32'd32;
         1:       return $urandom_range(63, 33);                   // clamps to 32
         2:       return $urandom_range(31, 5);
         default: return $urandom_range(4, 1);
      endcase
   endfunction

   // pcm side: check every transaction, random backpressure, one long hold-off
   initial begin
      bit held;
      held = 0;
      rsp_tready <= 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) pcm_model.check_pcm(rsp_tdata, rsp_tlast);
         if (!held && samples_sent >= 700) begin
            // sender keeps offering while the output side is blocked
            held = 1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= steady_stretch() || $urandom_range(99) >= 24;
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int target;
      pcm_model    = new();
      samples_sent = 0;
      reset        <= 1'b1;
      req_tvalid   <= 1'b0;
      req_tdata    <= '0;
      csr_we       <= 1'b0;
      csr_index    <= CSR_CHANNEL_COUNT;
      csr_wdata    <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: mono, step 1.0; first frame emits itself, then field rails
      send_sample(24'h7fffff);
      send_sample(24'h800000);
      send_sample(24'h000000);
      send_sample(24'hffffff);
      send_sample(24'h000001);
      wait_idle();

      // stereo at step 0.5: up to two outputs per frame, filter off
      program_block(2, 32'd8388608, 0);
      repeat (4) send_sample(pick_sample());
      wait_idle();

      // count zero acts as one, step zero raised to 0.5
      program_block(0, 32'd0, 0);
      repeat (3) send_sample(pick_sample());
      wait_idle();

      // top step with filter and rail coefficients; count above the maximum clamps
      program_block(63, 32'd201326592, 2);
      repeat (64) send_sample(24'h7fffff);
      wait_idle();

      // count lowered mid-frame: the partial frame closes on the next sample
      program_block(3, 32'd25165824, 0);
      send_sample(24'h400000);
      send_sample(24'hc00001);
      wait_idle();
      csr_write(CSR_CHANNEL_COUNT, 1);
      csr_we <= 1'b0;
      send_sample(24'h123456);
      wait_idle();

      // random phases, mostly small channel counts and tame filters
      target = samples_sent + RANDOM_ITEMS;
      while (samples_sent < target) begin
         int phase_len;
         program_block(pick_channels(), pick_step(), $urandom_range(9) < 7 ? 0 :
                       $urandom_range(1, 2));
         phase_len = $urandom_range(160, 40);
         repeat (phase_len) send_sample(pick_sample());
         wait_idle();
      end

      if (pcm_model.errors == 0 && pcm_model.expected_pcm.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
